// ===== rtl/core/cubic_bezier_flattener_core_assert.svh =====
// Assertion macros for the Bezier flattener core
`ifndef CUBIC_BEZIER_FLATTENER_CORE_ASSERT_SVH
`define CUBIC_BEZIER_FLATTENER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define CBF_ASSERT_IMPL(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define CBF_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("never failed");
`else
`define CBF_ASSERT_IMPL(label, prop)
`define CBF_ASSERT_NEVER(label, expr)
`endif
`endif

// ===== rtl/core/cbf_pkg.sv =====
`default_nettype none
package cbf_pkg;
  localparam int unsigned SegW   = 6;
  localparam int unsigned IdxW   = 7;
  localparam int unsigned FracW  = 17;  // t in Q1.16, 0..65536
  localparam int unsigned SegReset = 30;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [SegW-1:0] n;
    logic            last;
  } cbf_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/core/cbf_if.sv =====
`default_nettype none
interface cbf_in_if #(parameter int unsigned CoordW = 32);
  logic valid;
  logic ready;
  logic signed [CoordW-1:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
  logic drop_start;
  modport source (output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
    drop_start, input ready);
  modport sink (input valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
    drop_start, output ready);
endinterface

interface cbf_out_if #(parameter int unsigned CoordW = 32);
  logic valid;
  logic ready;
  logic signed [CoordW-1:0] x_out, y_out;
  logic last;
  modport source (output valid, x_out, y_out, last, input ready);
  modport sink (input valid, x_out, y_out, last, output ready);
endinterface

interface cbf_cfg_if;
  logic valid;
  logic ready;
  logic [5:0] nseg;
  modport source (output valid, nseg, input ready);
  modport sink (input valid, nseg, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cubic_bezier_flattener_core.sv =====
// Cubic Bezier flattener core.
// in_ch: one request carries the four control points and drop_start. The
//   block emits nseg+1 points at t = i/nseg (nseg points, without the t=0
//   point, when drop_start is set); an nseg of 0 acts as 1.
// out_ch: one point per cycle while the receiver takes them, last marks the t=1 point.
// cfg_ch: writes nseg; write only while no request is in flight. Reset 30.
// t = floor(i*65536/nseg) steps by a table quotient and a running remainder.
// Five register stages: t, squares, weights, coordinate products, sum.
// Throughput: one point per cycle while the receiver takes them; the next
//   request is taken only after the curve has left the weight stage, since
//   the control points are held until the product stage has used them.
// Every stage advances only when the output register is empty or taken, so
//   a stalled receiver holds the whole pipeline and loses nothing.
// Reset clears the valid bits and the sequencer and sets nseg to 30.
`default_nettype none
module cubic_bezier_flattener_core
  import cbf_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cbf_in_if.sink    in_ch,
  cbf_out_if.source out_ch,
  cbf_cfg_if.sink   cfg_ch
);
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned PW = CW + 18;  // product of coord and weight
  localparam int unsigned SW = CW + 20;  // sum of four
  localparam int unsigned RemW = SegW + 1;
  localparam int unsigned SqW = 2 * FracW;
  localparam int unsigned CubW = 3 * FracW;
  localparam int unsigned TabD = 1 << SegW;
  localparam logic [FracW-1:0] TOne = FracW'(65536);

  logic [SegW-1:0] seg_r;
  logic busy_r;
  logic [CW-1:0] cp_r [8];
  logic [IdxW-1:0] idx_r;
  logic [SegW-1:0] n_r;
  logic [FracW-1:0] t_r, qs_r;
  logic [SegW-1:0] rem_r, rs_r;
  logic adv, in_take;

  // 65536 = n*qs + rs for every n from 1 to 63; entry 0 holds the values for n = 1
  logic [FracW-1:0] qs_tab [TabD];
  logic [SegW-1:0]  rs_tab [TabD];
  for (genvar g = 0; g < TabD; g++) begin : g_step_tab
    localparam int unsigned Den = (g == 0) ? 1 : g;
    assign qs_tab[g] = FracW'(65536 / Den);
    assign rs_tab[g] = SegW'(65536 % Den);
  end

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) seg_r <= SegW'(SegReset);
    else if (cfg_ch.valid) seg_r <= cfg_ch.nseg;
  end

  // stage valids and payload
  logic v1_r, v2_r, v3_r, v4_r;
  logic l1_r, l2_r, l3_r, l4_r;
  logic [FracW-1:0] t1_r, u1_r;
  logic [SqW-1:0] uu2_r, tt2_r;
  logic [FracW-1:0] t2_r, u2_r;
  logic [FracW-1:0] w3_r [4];
  logic signed [PW-1:0] px4_r [4], py4_r [4];

  assign adv = !out_ch.valid || out_ch.ready;
  // hold new requests until the product stage is done with cp_r
  assign in_ch.ready = !busy_r && !v1_r && !v2_r && !v3_r;
  assign in_take = in_ch.valid && in_ch.ready;

  logic [SegW-1:0] n_eff;
  logic [RemW-1:0] rem_sum;
  logic carry, idx_last;
  logic [SegW-1:0] rem_nxt;
  logic [FracW-1:0] t_nxt;
  assign n_eff = (seg_r == '0) ? SegW'(1) : seg_r;
  assign rem_sum = RemW'(rem_r) + RemW'(rs_r);
  assign carry = rem_sum >= RemW'(n_r);
  assign rem_nxt = carry ? SegW'(rem_sum - RemW'(n_r)) : SegW'(rem_sum);
  assign t_nxt = t_r + qs_r + FracW'(carry);
  assign idx_last = (idx_r == IdxW'(n_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (in_take) begin
      busy_r <= 1'b1;
      n_r <= n_eff;
      qs_r <= qs_tab[n_eff];
      rs_r <= rs_tab[n_eff];
      // start at index 1 when the t=0 point is dropped
      idx_r <= in_ch.drop_start ? IdxW'(1) : '0;
      t_r <= in_ch.drop_start ? qs_tab[n_eff] : '0;
      rem_r <= in_ch.drop_start ? rs_tab[n_eff] : '0;
      cp_r[0] <= in_ch.p0_x; cp_r[1] <= in_ch.p0_y;
      cp_r[2] <= in_ch.p1_x; cp_r[3] <= in_ch.p1_y;
      cp_r[4] <= in_ch.p2_x; cp_r[5] <= in_ch.p2_y;
      cp_r[6] <= in_ch.p3_x; cp_r[7] <= in_ch.p3_y;
    end else if (adv) begin
      v1_r <= busy_r;
      if (busy_r) begin
        t1_r <= t_r;
        u1_r <= TOne - t_r;
        l1_r <= idx_last;
        t_r <= t_nxt;
        rem_r <= rem_nxt;
        idx_r <= idx_r + IdxW'(1);
        if (idx_last) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; out_ch.valid <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; out_ch.valid <= v4_r;
    end
  end

  logic [CubW-1:0] m0, m1, m2, m3;
  logic [CubW:0] m1x3, m2x3;
  logic signed [SW-1:0] sx, sy;
  always_comb begin
    m0 = CubW'(uu2_r) * CubW'(u2_r);
    m1 = CubW'(uu2_r) * CubW'(t2_r);
    m2 = CubW'(tt2_r) * CubW'(u2_r);
    m3 = CubW'(tt2_r) * CubW'(t2_r);
    m1x3 = {m1, 1'b0} + (CubW+1)'(m1);
    m2x3 = {m2, 1'b0} + (CubW+1)'(m2);
    sx = SW'(px4_r[0]) + SW'(px4_r[1]) + SW'(px4_r[2]) + SW'(px4_r[3]);
    sy = SW'(py4_r[0]) + SW'(py4_r[1]) + SW'(py4_r[2]) + SW'(py4_r[3]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      uu2_r <= SqW'(u1_r) * SqW'(u1_r);
      tt2_r <= SqW'(t1_r) * SqW'(t1_r);
      t2_r <= t1_r; u2_r <= u1_r; l2_r <= l1_r;
      w3_r[0] <= FracW'(m0 >> 32); w3_r[1] <= FracW'(m1x3 >> 32);
      w3_r[2] <= FracW'(m2x3 >> 32); w3_r[3] <= FracW'(m3 >> 32);
      l3_r <= l2_r;
      for (int k = 0; k < 4; k++) begin
        px4_r[k] <= PW'($signed(cp_r[2*k])) * PW'($signed({1'b0, w3_r[k]}));
        py4_r[k] <= PW'($signed(cp_r[2*k+1])) * PW'($signed({1'b0, w3_r[k]}));
      end
      l4_r <= l3_r;
      out_ch.x_out <= CW'(sx >>> 16);
      out_ch.y_out <= CW'(sy >>> 16);
      out_ch.last <= l4_r;
    end
  end

  `include "cubic_bezier_flattener_core_assert.svh"
  `CBF_ASSERT_NEVER(a_take_busy, busy_r && in_ch.ready)
  `CBF_ASSERT_IMPL(a_out_hold, (out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.x_out) && $stable(out_ch.y_out) && $stable(out_ch.last)))
endmodule
`default_nettype wire

// ===== dv/tb_cubic_bezier_flattener_core.sv =====
`timescale 1ns / 1ps
module tb_cubic_bezier_flattener_core;
  import cbf_pkg::*;

  localparam int unsigned CW = 32;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last;
  } point_t;

  typedef struct {
    logic signed [CW-1:0] c[8];
    logic                 skip;
    logic                 has_exp;  // first expected point typed in
    point_t               exp0;
  } curve_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  cbf_in_if  #(.CoordW(CW)) in_ch ();
  cbf_out_if #(.CoordW(CW)) out_ch ();
  cbf_cfg_if cfg_ch ();

  cubic_bezier_flattener_core #(.COORD_WIDTH(CW)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  point_t      expected_points[$];
  logic [5:0]  seg_count;
  int          errors = 0;
  int          cycles = 0;
  bit          calm = 1'b0;
  int          out_hold = 0;
  curve_req_t  directed[$];

  task automatic report_mismatch(input string what, input point_t got, input point_t want);
    $display("mismatch %s: got x=%h y=%h last=%b want x=%h y=%h last=%b",
             what, got.x, got.y, got.last, want.x, want.y, want.last);
    errors++;
  endtask

  function automatic logic signed [CW-1:0] blend_coord(
      input logic signed [CW-1:0] a, b, c, d, input logic [63:0] w[4]);
    logic signed [63:0] s;
    s = 64'(a) * $signed(w[0]) + 64'(b) * $signed(w[1])
      + 64'(c) * $signed(w[2]) + 64'(d) * $signed(w[3]);
    return CW'(s >>> 16);
  endfunction

  task automatic predict_curve(input curve_req_t r);
    logic [63:0] n, t, u;
    logic [63:0] w[4];
    point_t p;
    n = (seg_count == 0) ? 64'd1 : 64'(seg_count);
    for (int i = r.skip ? 1 : 0; i <= n; i++) begin
      t = (64'(i) << 16) / n;
      u = 64'd65536 - t;
      w[0] = (u * u * u) >> 32;
      w[1] = (3 * u * u * t) >> 32;
      w[2] = (3 * u * t * t) >> 32;
      w[3] = (t * t * t) >> 32;
      p.x = blend_coord(r.c[0], r.c[2], r.c[4], r.c[6], w);
      p.y = blend_coord(r.c[1], r.c[3], r.c[5], r.c[7], w);
      p.last = (i == n);
      if (i == (r.skip ? 1 : 0) && r.has_exp && p != r.exp0)
        report_mismatch("typed-in", p, r.exp0);
      expected_points.push_back(p);
    end
  endtask

  // receiver side: sample at rising edge, stall in bursts
  always @(posedge clk) begin
    point_t got, want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.x_out, out_ch.y_out, out_ch.last};
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected", got, '0);
      end else begin
        want = expected_points.pop_front();
        if (got.x !== want.x) report_mismatch("x_out", got, want);
        else if (got.y !== want.y) report_mismatch("y_out", got, want);
        else if (got.last !== want.last) report_mismatch("last", got, want);
      end
    end
  end

  always @(negedge clk) begin
    if (calm) out_ch.ready <= 1'b1;
    else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      out_hold <= $urandom_range(1, 15) - 1;
      out_ch.ready <= 1'b0;
    end else out_ch.ready <= 1'b1;
  end

  task automatic write_segments(input logic [5:0] v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.nseg <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    seg_count = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_curve(input curve_req_t r);
    if (!calm && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 15)) @(negedge clk);
    @(negedge clk);
    in_ch.valid <= 1'b1;
    {in_ch.p0_x, in_ch.p0_y, in_ch.p1_x, in_ch.p1_y} <= {r.c[0], r.c[1], r.c[2], r.c[3]};
    {in_ch.p2_x, in_ch.p2_y, in_ch.p3_x, in_ch.p3_y} <= {r.c[4], r.c[5], r.c[6], r.c[7]};
    in_ch.drop_start <= r.skip;
    do @(posedge clk); while (!in_ch.ready);
    predict_curve(r);
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return CW'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic curve_req_t make_curve(input logic signed [CW-1:0] v[8],
      input logic skip, input logic has, input point_t e);
    curve_req_t r;
    r.c = v; r.skip = skip; r.has_exp = has; r.exp0 = e;
    return r;
  endfunction

  initial begin
    curve_req_t r;
    logic signed [CW-1:0] v[8];
    logic signed [CW-1:0] mx, mn;
    mx = 32'sh7fffffff; mn = 32'sh80000000;
    in_ch.valid = 0; cfg_ch.valid = 0; cfg_ch.nseg = 0;
    {in_ch.p0_x, in_ch.p0_y, in_ch.p1_x, in_ch.p1_y} = '0;
    {in_ch.p2_x, in_ch.p2_y, in_ch.p3_x, in_ch.p3_y} = '0;
    in_ch.drop_start = 0;
    seg_count = 6'(SegReset);
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // start point comes out exactly; skip gives the t=1/n point (predicted)
    directed.push_back(make_curve('{mx, mn, mx, mn, mx, mn, mx, mn}, 0, 1, '{mx, mn, 1'b0}));
    directed.push_back(make_curve('{mn, mx, mn, mx, mn, mx, mn, mx}, 0, 1, '{mn, mx, 1'b0}));
    directed.push_back(make_curve('{0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, '{0, 0, 0}));
    directed.push_back(make_curve('{-1, -1, -1, -1, -1, -1, -1, -1}, 1, 0, '{0, 0, 0}));
    directed.push_back(make_curve('{mn, mn, mx, mx, mn, mn, mx, mx}, 0, 1, '{mn, mn, 1'b0}));
    directed.push_back(make_curve('{0, 0, 32'sh10000, 0, 32'sh10000, 32'sh10000, 0,
                                    32'sh10000}, 1, 0, '{0, 0, 0}));
    foreach (directed[k]) send_curve(directed[k]);
    drain();

    // zero segment count acts as one: start and end points
    write_segments(6'd0);
    send_curve(make_curve('{1, 2, 3, 4, 5, 6, 7, 8}, 0, 1, '{1, 2, 1'b0}));
    send_curve(make_curve('{mx, mn, 0, 0, 0, 0, mn, mx}, 1, 1, '{mn, mx, 1'b1}));
    drain();
    write_segments(6'd1);
    send_curve(make_curve('{mn, mx, 5, 5, 5, 5, mx, mn}, 1, 1, '{mx, mn, 1'b1}));
    drain();
    write_segments(6'd63);
    send_curve(make_curve('{mx, mx, mn, mn, mx, mx, mn, mn}, 0, 1, '{mx, mx, 1'b0}));
    send_curve(make_curve('{mn, mn, mx, mx, mn, mn, mx, mx}, 1, 0, '{0, 0, 0}));
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 7) calm = 1'b1;
      // mostly short curves keep the run quick
      write_segments(phase == 3 ? 6'd63 : 6'($urandom_range(0, 12)));
      for (int k = 0; k < 12; k++) begin
        foreach (v[j]) v[j] = rand_coord();
        send_curve(make_curve(v, 1'($urandom_range(0, 1)), 0, '{0, 0, 0}));
      end
      drain();
    end

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
